>>> hw/rtl/okl_pkg.sv
// Shared types, constants and helpers for the Oklab colour blend pipeline.
// The sRGB decode table is built at elaboration. No dependencies.
package okl_pkg;

   localparam int LIN_W       = 17;
   localparam int COEF_W      = 20;
   localparam int CBRT_W      = 17;
   localparam int CBRT_STAGES = CBRT_W;
   localparam int MAT_LAT     = 2;

   typedef struct packed {
      logic [7:0]  start_red;
      logic [7:0]  start_green;
      logic [7:0]  start_blue;
      logic [7:0]  start_alpha;
      logic [7:0]  end_red;
      logic [7:0]  end_green;
      logic [7:0]  end_blue;
      logic [7:0]  end_alpha;
      logic [16:0] weight;
   } req_type;

   typedef struct packed {
      logic [7:0] mix_red;
      logic [7:0] mix_green;
      logic [7:0] mix_blue;
      logic [7:0] mix_alpha;
   } rsp_type;

   typedef logic signed [COEF_W-1:0] mat_type [3][3];
   typedef logic [LIN_W-1:0] dec_rom_type [256];

   localparam mat_type LIN_TO_LMS = '{
      '{20'sd27015, 20'sd35149, 20'sd3372},
      '{20'sd13887, 20'sd44610, 20'sd7039},
      '{20'sd5787,  20'sd18463, 20'sd41286}};
   localparam mat_type LMS_TO_LAB = '{
      '{20'sd13792,  20'sd52011,   -20'sd267},
      '{20'sd129630, -20'sd159160, 20'sd29530},
      '{20'sd1698,   20'sd51300,   -20'sd52998}};
   localparam mat_type LAB_TO_LMS = '{
      '{20'sd65536, 20'sd25974, 20'sd14143},
      '{20'sd65536, -20'sd6918, -20'sd4185},
      '{20'sd65536, -20'sd5864, -20'sd84639}};
   localparam mat_type LMS_TO_LIN = '{
      '{20'sd267173,  -20'sd216774, 20'sd15137},
      '{-20'sd83128,  20'sd171033,  -20'sd22369},
      '{-20'sd275,    -20'sd46099,  20'sd111910}};

   // round to nearest, ties away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned n);
      logic signed [63:0] half;
      half = 64'sd1 <<< (n - 1);
      if (v >= 0) begin
         return (v + half) >>> n;
      end
      return -((-v + half) >>> n);
   endfunction

   function automatic longint unsigned pow5_q30(input longint unsigned r);
      longint unsigned p;
      p = r;
      for (int i = 0; i < 4; i++) begin
         p = (p * r) >> 30;
      end
      return p;
   endfunction

   function automatic dec_rom_type build_decode_rom();
      dec_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned r;
      longint unsigned cand;
      longint unsigned y;
      longint unsigned kk;
      for (int k = 0; k < 256; k++) begin
         kk = longint'(k);
         if (k <= 10) begin
            rom[k] = LIN_W'((kk * 64'd6553600 + 64'd164730) / 64'd329460);
         end else begin
            x  = ((64'd1000 * kk + 64'd14025) << 30) / 64'd269025;
            x2 = (x * x) >> 30;
            r  = 0;
            for (int b = 30; b >= 0; b--) begin
               cand = r | (64'd1 << b);
               if (cand <= (64'd1 << 30) && pow5_q30(cand) <= x2) begin
                  r = cand;
               end
            end
            y      = (x2 * r) >> 30;
            rom[k] = LIN_W'((y + 64'd8192) >> 14);
         end
      end
      return rom;
   endfunction

   localparam dec_rom_type DECODE_ROM = build_decode_rom();

endpackage

>>> hw/rtl/okl_mat3.sv
// Pipelined 3x3 fixed-point matrix: products, then row sums rounded to Q16.
// Depends on okl_pkg.
module okl_mat3 #(
   parameter int IN_W  = 18,
   parameter int OUT_W = 18,
   parameter okl_pkg::mat_type COEF = okl_pkg::LIN_TO_LMS
) (
   input  logic                    clock,
   input  logic signed [IN_W-1:0]  vec_i [3],
   output logic signed [OUT_W-1:0] vec_o [3]
);
   import okl_pkg::*;

   localparam int PROD_W = IN_W + COEF_W;
   localparam int SUM_W  = PROD_W + 2;

   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [OUT_W-1:0]  out_ff  [3];
   logic signed [OUT_W-1:0]  out_in  [3];
   logic signed [SUM_W-1:0]  sum     [3];
   logic signed [63:0]       rnd     [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[i][j] <= PROD_W'(vec_i[j]) * PROD_W'(COEF[i][j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i]    = SUM_W'(prod_ff[i][0]) + SUM_W'(prod_ff[i][1]) + SUM_W'(prod_ff[i][2]);
         rnd[i]    = round_shift(64'(sum[i]), 16);
         out_in[i] = rnd[i][OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign vec_o = out_ff;

endmodule

>>> hw/rtl/okl_cbrt.sv
// Floor cube root in Q16, one result bit per stage. Square and cube of the
// partial root are carried along, so each stage needs shifts and adds only.
// Depends on okl_pkg.
module okl_cbrt (
   input  logic              clock,
   input  logic [okl_pkg::CBRT_W-1:0] v_i,
   output logic [okl_pkg::CBRT_W-1:0] c_o
);
   import okl_pkg::*;

   localparam int C2_W = 2 * CBRT_W;
   localparam int C3_W = 3 * CBRT_W;

   logic [CBRT_W-1:0] v_ff  [CBRT_STAGES];
   logic [CBRT_W-1:0] c_ff  [CBRT_STAGES];
   logic [C2_W-1:0]   c2_ff [CBRT_STAGES];
   logic [C3_W-1:0]   c3_ff [CBRT_STAGES];

   for (genvar s = 0; s < CBRT_STAGES; s++) begin : g_stage
      localparam int B = CBRT_W - 1 - s;
      logic [CBRT_W-1:0] v_p;
      logic [CBRT_W-1:0] c_p;
      logic [C2_W-1:0]   c2_p;
      logic [C3_W-1:0]   c3_p;
      logic [C3_W-1:0]   cand3;
      logic [C3_W-1:0]   target;
      logic              take;

      if (s == 0) begin : g_first
         assign v_p  = v_i;
         assign c_p  = '0;
         assign c2_p = '0;
         assign c3_p = '0;
      end else begin : g_next
         assign v_p  = v_ff[s-1];
         assign c_p  = c_ff[s-1];
         assign c2_p = c2_ff[s-1];
         assign c3_p = c3_ff[s-1];
      end

      // (c + 2^B)^3 = c^3 + 3c^2 2^B + 3c 2^2B + 2^3B
      assign cand3  = c3_p + ((C3_W'(c2_p) * 3) << B) + ((C3_W'(c_p) * 3) << (2 * B))
                      + (C3_W'(1) << (3 * B));
      assign target = C3_W'({v_p, 32'd0});
      assign take   = cand3 <= target;

      always_ff @(posedge clock) begin
         v_ff[s] <= v_p;
         if (take) begin
            c_ff[s]  <= c_p | (CBRT_W'(1) << B);
            c2_ff[s] <= c2_p + (C2_W'(c_p) << (B + 1)) + (C2_W'(1) << (2 * B));
            c3_ff[s] <= cand3;
         end else begin
            c_ff[s]  <= c_p;
            c2_ff[s] <= c2_p;
            c3_ff[s] <= c3_p;
         end
      end
   end

   assign c_o = c_ff[CBRT_STAGES-1];

endmodule

>>> hw/rtl/oklab_color_interpolator_unit.sv
// Top level of the Oklab colour blend: decode, Oklab forward, lerp, inverse,
// cube, encode. Depends on okl_pkg, okl_mat3 and okl_cbrt.
//
//   channel   ports                   direction   flow
//   request   start, busy, req_data   in          start & !busy takes a word
//   response  rsp_strobe, rsp_data    out         one-cycle strobe, no back-pressure
//
// One word enters every cycle; busy is never raised.
// The depth of the pipe from a taken word to its result is set by the 17-stage
// cube root, four matrix units, the cubing stages and the 8-stage encode search.
// Reset clears the valid pipe only; payload stages run free.
// The receiver cannot stall, so the pipe never holds.
module oklab_color_interpolator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  okl_pkg::req_type req_data,
   output logic             rsp_strobe,
   output okl_pkg::rsp_type rsp_data
);
   import okl_pkg::*;

   localparam int LERP_LAT   = 2;
   localparam int CUBE_LAT   = 3;
   localparam int ENC_STAGES = 8;
   localparam int T_DLY      = 1 + 2 * MAT_LAT + CBRT_STAGES;
   localparam int A_DLY      = 4 * MAT_LAT + CBRT_STAGES + LERP_LAT + CUBE_LAT + ENC_STAGES;
   localparam int V_LEN      = A_DLY + 2;
   localparam logic [16:0] Q_ONE = 17'd65536;
   localparam logic signed [21:0] LMS_LIM = 22'sd262144;

   logic accept;
   logic [V_LEN-1:0] vld_ff;
   req_type     in_ff;
   logic [16:0] t1_ff;
   logic [16:0] t_ff [T_DLY];
   logic [7:0]  a_ff [A_DLY+1];
   logic [7:0]  alpha_in;
   logic [LIN_W-1:0] lin_ff [2][3];
   logic [7:0]  col [2][3];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[V_LEN-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= req_data;
      t1_ff <= (req_data.weight > Q_ONE) ? Q_ONE : req_data.weight;
   end

   assign col[0][0] = in_ff.start_red;
   assign col[0][1] = in_ff.start_green;
   assign col[0][2] = in_ff.start_blue;
   assign col[1][0] = in_ff.end_red;
   assign col[1][1] = in_ff.end_green;
   assign col[1][2] = in_ff.end_blue;

   always_comb begin
      logic [25:0] asum;
      asum = 26'(in_ff.start_alpha) * 26'(Q_ONE - t1_ff)
             + 26'(in_ff.end_alpha) * 26'(t1_ff);
      alpha_in = asum[23:16];
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < 2; g++) begin
         for (int i = 0; i < 3; i++) begin
            lin_ff[g][i] <= DECODE_ROM[col[g][i]];
         end
      end
      t_ff[0] <= t1_ff;
      for (int k = 1; k < T_DLY; k++) begin
         t_ff[k] <= t_ff[k-1];
      end
      a_ff[0] <= alpha_in;
      for (int k = 1; k <= A_DLY; k++) begin
         a_ff[k] <= a_ff[k-1];
      end
   end

   // forward transform for both colours
   logic signed [17:0] lin_s  [2][3];
   logic signed [17:0] lms1   [2][3];
   logic [CBRT_W-1:0]  root   [2][3];
   logic signed [17:0] root_s [2][3];
   logic signed [19:0] lab    [2][3];

   for (genvar g = 0; g < 2; g++) begin : g_fwd
      for (genvar i = 0; i < 3; i++) begin : g_ch
         assign lin_s[g][i]  = {1'b0, lin_ff[g][i]};
         assign root_s[g][i] = {1'b0, root[g][i]};
         okl_cbrt u_cbrt (
            .clock (clock),
            .v_i   (lms1[g][i][CBRT_W-1:0]),
            .c_o   (root[g][i])
         );
      end
      okl_mat3 #(.IN_W(18), .OUT_W(18), .COEF(LIN_TO_LMS)) u_lin2lms (
         .clock (clock),
         .vec_i (lin_s[g]),
         .vec_o (lms1[g])
      );
      okl_mat3 #(.IN_W(18), .OUT_W(20), .COEF(LMS_TO_LAB)) u_lms2lab (
         .clock (clock),
         .vec_i (root_s[g]),
         .vec_o (lab[g])
      );
   end

   // lerp in Oklab
   logic signed [38:0] lerp_prod_ff [3];
   logic signed [19:0] lerp_base_ff [3];
   logic signed [19:0] mix_ff       [3];
   logic signed [63:0] lerp_rnd     [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lerp_rnd[i] = round_shift(64'(lerp_prod_ff[i]), 16);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         lerp_prod_ff[i] <= 39'(21'(lab[1][i]) - 21'(lab[0][i]))
                            * 39'($signed({1'b0, t_ff[T_DLY-1]}));
         lerp_base_ff[i] <= lab[0][i];
         mix_ff[i]       <= lerp_base_ff[i] + lerp_rnd[i][19:0];
      end
   end

   // inverse transform and cubing
   logic signed [21:0] lms2     [3];
   logic signed [19:0] clamp    [3];
   logic signed [19:0] cv_ff    [3];
   logic signed [39:0] sq_ff    [3];
   logic signed [59:0] cube_ff  [3];
   logic signed [23:0] lms3_ff  [3];
   logic signed [63:0] cube_rnd [3];
   logic signed [29:0] lin_o    [3];

   okl_mat3 #(.IN_W(20), .OUT_W(22), .COEF(LAB_TO_LMS)) u_lab2lms (
      .clock (clock),
      .vec_i (mix_ff),
      .vec_o (lms2)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (lms2[i] > LMS_LIM) begin
            clamp[i] = LMS_LIM[19:0];
         end else if (lms2[i] < -LMS_LIM) begin
            clamp[i] = 20'(-LMS_LIM);
         end else begin
            clamp[i] = lms2[i][19:0];
         end
         cube_rnd[i] = round_shift(64'(cube_ff[i]), 32);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         cv_ff[i]   <= clamp[i];
         sq_ff[i]   <= 40'(clamp[i]) * 40'(clamp[i]);
         cube_ff[i] <= 60'(sq_ff[i]) * 60'(cv_ff[i]);
         lms3_ff[i] <= cube_rnd[i][23:0];
      end
   end

   okl_mat3 #(.IN_W(24), .OUT_W(30), .COEF(LMS_TO_LIN)) u_lms2lin (
      .clock (clock),
      .vec_i (lms3_ff),
      .vec_o (lin_o)
   );

   // sRGB encode: binary search of the decode table, one code bit a stage
   logic [7:0]         enc_code_ff [ENC_STAGES][3];
   logic signed [29:0] enc_lin_ff  [ENC_STAGES][3];

   for (genvar k = 0; k < ENC_STAGES; k++) begin : g_enc
      for (genvar i = 0; i < 3; i++) begin : g_ch
         logic [7:0]         prev_code;
         logic signed [29:0] prev_lin;
         logic [7:0]         cand;
         logic               ge;
         if (k == 0) begin : g_first
            assign prev_code = '0;
            assign prev_lin  = lin_o[i];
         end else begin : g_next
            assign prev_code = enc_code_ff[k-1][i];
            assign prev_lin  = enc_lin_ff[k-1][i];
         end
         assign cand = prev_code | (8'd1 << (ENC_STAGES - 1 - k));
         assign ge   = prev_lin >= $signed({13'd0, DECODE_ROM[cand]});
         always_ff @(posedge clock) begin
            enc_code_ff[k][i] <= ge ? cand : prev_code;
            enc_lin_ff[k][i]  <= prev_lin;
         end
      end
   end

   assign rsp_strobe         = vld_ff[V_LEN-1];
   assign rsp_data.mix_red   = enc_code_ff[ENC_STAGES-1][0];
   assign rsp_data.mix_green = enc_code_ff[ENC_STAGES-1][1];
   assign rsp_data.mix_blue  = enc_code_ff[ENC_STAGES-1][2];
   assign rsp_data.mix_alpha = a_ff[A_DLY];

endmodule

>>> verif/oklab_color_interpolator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for oklab_color_interpolator_unit: random and corner colour pairs,
// predicted in fixed point and compared word by word. Depends on okl_pkg.
module oklab_color_interpolator_unit_test;
   import okl_pkg::*;

   typedef longint signed vec3_type [3];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int unsigned cycle_count = 0;
   int unsigned n_sent = 0;
   int unsigned n_got = 0;

   // sRGB decode table, built here independently
   longint unsigned srgb_lut [256];

   function automatic longint signed rnd_shift(longint signed v, int n);
      longint signed half;
      half = 64'sd1 <<< (n - 1);
      if (v >= 0) begin
         return (v + half) >>> n;
      end
      return -((-v + half) >>> n);
   endfunction

   function automatic longint unsigned fifth_pow(longint unsigned r);
      longint unsigned p;
      p = r;
      for (int i = 0; i < 4; i++) begin
         p = (p * r) >> 30;
      end
      return p;
   endfunction

   task automatic fill_lut();
      longint unsigned x, x2, r, c, y;
      for (int k = 0; k < 256; k++) begin
         if (k <= 10) begin
            srgb_lut[k] = (longint'(k) * 6553600 + 164730) / 329460;
         end else begin
            x  = ((1000 * longint'(k) + 14025) << 30) / 269025;
            x2 = (x * x) >> 30;
            r  = 0;
            for (int b = 30; b >= 0; b--) begin
               c = r | (64'd1 << b);
               if (c <= (64'd1 << 30) && fifth_pow(c) <= x2) r = c;
            end
            y = (x2 * r) >> 30;
            srgb_lut[k] = (y + 8192) >> 14;
         end
      end
   endtask

   function automatic vec3_type mul3(int m [3][3], vec3_type v);
      vec3_type o;
      for (int i = 0; i < 3; i++) begin
         o[i] = rnd_shift(longint'(m[i][0]) * v[0] + longint'(m[i][1]) * v[1]
                          + longint'(m[i][2]) * v[2], 16);
      end
      return o;
   endfunction

   function automatic longint signed cbrt_floor(longint signed v);
      longint unsigned tgt, c, cand;
      if (v <= 0) return 0;
      if (v > (64'sd1 <<< 20)) v = 64'sd1 <<< 20;
      tgt = longint'(v) << 32;
      c = 0;
      for (int b = 17; b >= 0; b--) begin
         cand = c | (64'd1 << b);
         if (cand * cand * cand <= tgt) c = cand;
      end
      return c;
   endfunction

   function automatic vec3_type rgb_to_lab(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int m1 [3][3] = '{'{27015, 35149, 3372}, '{13887, 44610, 7039},
                        '{5787, 18463, 41286}};
      int m2 [3][3] = '{'{13792, 52011, -267}, '{129630, -159160, 29530},
                        '{1698, 51300, -52998}};
      vec3_type v;
      v[0] = srgb_lut[r];
      v[1] = srgb_lut[g];
      v[2] = srgb_lut[b];
      v = mul3(m1, v);
      for (int i = 0; i < 3; i++) v[i] = cbrt_floor(v[i]);
      return mul3(m2, v);
   endfunction

   function automatic logic [7:0] lin_to_code(longint signed lin);
      logic [7:0] code;
      code = 0;
      if (lin < 0) return 0;
      for (int j = 1; j < 256; j++) begin
         if (lin >= longint'(srgb_lut[j])) code = j[7:0];
      end
      return code;
   endfunction

   function automatic rsp_type blend_colour(req_type q);
      int m3 [3][3] = '{'{65536, 25974, 14143}, '{65536, -6918, -4185},
                        '{65536, -5864, -84639}};
      int m4 [3][3] = '{'{267173, -216774, 15137}, '{-83128, 171033, -22369},
                        '{-275, -46099, 111910}};
      vec3_type a, b, m;
      longint signed t, v;
      rsp_type o;
      t = (q.weight > 17'd65536) ? 65536 : q.weight;
      a = rgb_to_lab(q.start_red, q.start_green, q.start_blue);
      b = rgb_to_lab(q.end_red, q.end_green, q.end_blue);
      for (int i = 0; i < 3; i++) m[i] = a[i] + rnd_shift((b[i] - a[i]) * t, 16);
      m = mul3(m3, m);
      for (int i = 0; i < 3; i++) begin
         v = m[i];
         if (v > (64'sd1 <<< 18)) v = 64'sd1 <<< 18;
         if (v < -(64'sd1 <<< 18)) v = -(64'sd1 <<< 18);
         m[i] = rnd_shift(v * v * v, 32);
      end
      m = mul3(m4, m);
      o.mix_red   = lin_to_code(m[0]);
      o.mix_green = lin_to_code(m[1]);
      o.mix_blue  = lin_to_code(m[2]);
      o.mix_alpha = 8'((longint'(q.start_alpha) * (65536 - t) + longint'(q.end_alpha) * t) >> 16);
      return o;
   endfunction

   class blend_scoreboard;
      rsp_type pending [$];
      int unsigned errors = 0;

      function void note_word(req_type q);
         pending.push_back(blend_colour(q));
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding: %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.mix_red !== want.mix_red) begin
            $error("mix_red exp %0d got %0d", want.mix_red, got.mix_red);
            errors++;
         end
         if (got.mix_green !== want.mix_green) begin
            $error("mix_green exp %0d got %0d", want.mix_green, got.mix_green);
            errors++;
         end
         if (got.mix_blue !== want.mix_blue) begin
            $error("mix_blue exp %0d got %0d", want.mix_blue, got.mix_blue);
            errors++;
         end
         if (got.mix_alpha !== want.mix_alpha) begin
            $error("mix_alpha exp %0d got %0d", want.mix_alpha, got.mix_alpha);
            errors++;
         end
      endfunction
   endclass

   blend_scoreboard sb = new();

   oklab_color_interpolator_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && start && !busy) begin
         sb.note_word(req_data);
         n_sent <= n_sent + 1;
      end
      if (!reset && rsp_strobe) begin
         sb.check_word(rsp_data);
         n_got <= n_got + 1;
      end
   end

   initial begin
      wait (cycle_count > 400000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hold start for one word, stay high if another follows
   task automatic send_word(req_type q, bit idle_ok);
      int gap;
      req_data <= q;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (idle_ok && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_chan();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 12));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_type random_word();
      req_type q;
      q.start_red = pick_chan();  q.start_green = pick_chan();
      q.start_blue = pick_chan(); q.start_alpha = pick_chan();
      q.end_red = pick_chan();    q.end_green = pick_chan();
      q.end_blue = pick_chan();   q.end_alpha = pick_chan();
      case ($urandom_range(0, 7))
         0: q.weight = 17'd0;
         1: q.weight = 17'd65536;
         2: q.weight = 17'($urandom_range(65537, 131071));
         default: q.weight = 17'($urandom_range(0, 65536));
      endcase
      return q;
   endfunction

   initial begin
      req_type q;
      fill_lut();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // corners: black/white, primaries, weight ends and over-range
      send_word('{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 17'd0}, 0);
      send_word('{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 17'd65536}, 0);
      send_word('{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 17'd32768}, 0);
      send_word('{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 17'd32768}, 0);
      send_word('{8'd0, 8'd255, 8'd0, 8'd17, 8'd255, 8'd0, 8'd255, 8'd200, 17'd131071}, 0);
      send_word('{8'd10, 8'd11, 8'd1, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 17'd65537}, 0);
      send_word('{8'd255, 8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd255, 8'd127, 17'd1}, 0);
      send_word('{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 17'd65535}, 0);
      send_word('{8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 8'h55, 17'h15555}, 0);
      send_word('{8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa, 8'h55, 8'haa, 17'h0aaaa}, 0);
      for (int i = 0; i < 1550; i++) begin
         if (i == 600) begin
            // drain the pipe completely once
            start <= 1'b0;
            @(posedge clock);
            while (sb.pending.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         q = random_word();
         send_word(q, i < 1300);
      end
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d colour pairs sent, %0d blends checked (corners, over-range weights).",
               n_sent, n_got);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
